// ----- rtl/lbs_pkg.sv -----
// lbs_pkg: shared types, constants and helper functions of the skinning core
package lbs_pkg;

    localparam int DEF_BONE_COUNT    = 64;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int WORD_W         = 32;
    localparam int ACC_W          = 64;
    localparam int BONE_W         = 6;
    localparam int SLOT_W         = 4;
    localparam int WEIGHT_W       = 16;
    localparam int WEIGHT_SHIFT   = 15;
    localparam int SLOTS_PER_BONE = 12;
    localparam int SLOT_SPAN      = 1 << SLOT_W;

    localparam logic ACTION_WRITE     = 1'b0;
    localparam logic ACTION_INFLUENCE = 1'b1;

    localparam logic [1:0] ROW_LAST = 2'd2;
    localparam logic [1:0] COL_X    = 2'd0;
    localparam logic [1:0] COL_Y    = 2'd1;
    localparam logic [1:0] COL_Z    = 2'd2;

    localparam logic [3:0] STEP_RD0 = 4'd0;
    localparam logic [3:0] STEP_RD1 = 4'd1;
    localparam logic [3:0] STEP_RD2 = 4'd2;
    localparam logic [3:0] STEP_RD3 = 4'd3;
    localparam logic [3:0] STEP_M3  = 4'd4;
    localparam logic [3:0] STEP_LO  = 4'd5;
    localparam logic [3:0] STEP_HI  = 4'd6;
    localparam logic [3:0] STEP_WT  = 4'd7;
    localparam logic [3:0] STEP_ACC = 4'd8;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_EMIT
    } seq_state_t;

    typedef struct packed {
        logic                     action;
        logic [BONE_W-1:0]        bone_index;
        logic [SLOT_W-1:0]        matrix_slot;
        logic signed [WORD_W-1:0] matrix_value;
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic [WEIGHT_W-1:0]      weight;
        logic                     last_influence;
    } lbs_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic                     clipped;
    } lbs_out_t;

    typedef struct packed {
        logic       rd_en;
        logic [1:0] row;
        logic [1:0] rd_col;
        logic [1:0] p_col;
        logic       mul_mat;
        logic       mul_lo;
        logic       mul_hi;
        logic       t_clr;
        logic       t_add;
        logic       t_last;
        logic       lo_cap;
        logic       wt_cap;
        logic       acc_upd;
        logic       emit;
    } lbs_ctrl_t;

    // saturating 64-bit signed add
    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1])
            begin
                sat_add64 = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end
            else
            begin
                sat_add64 = s[ACC_W-1:0];
            end
        end
    endfunction

    // clip flag in the top bit, saturated word below
    function automatic logic [WORD_W:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic fits;
        begin
            fits = (&v[ACC_W-1:WORD_W-1]) | ~(|v[ACC_W-1:WORD_W-1]);
            if (fits)
            begin
                sat_word = {1'b0, v[WORD_W-1:0]};
            end
            else if (v[ACC_W-1])
            begin
                sat_word = {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
            end
            else
            begin
                sat_word = {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
            end
        end
    endfunction

endpackage

// ----- rtl/linear_blend_skinning_core.sv -----
// linear_blend_skinning_core: top level of the vertex skinning engine
//
// item channel: item_valid / item_stall / item. action 0 writes one palette word
// (bone_index, matrix_slot, matrix_value) if bone and slot are in range. action 1
// is one bone influence: rest position, bone index, unsigned Q1.15 weight and
// last mark. an influence for a bone in range keeps item_stall high while its
// three matrix rows are worked through, paced by the single 33x33 multiplier
// (three matrix products and two weight products per row) and the one-word read
// port of the palette ram (four reads per row). an influence for a bone out of
// range adds nothing.
// result channel: result_valid / result_stall / result. the last influence of a
// vertex gives one result, loaded into the output register from the emit state
// that follows its last row (or the influence itself, for a bone out of range),
// and result_valid rises with that load; item_stall also covers the emit state.
// the output register lets the next item be taken while a result waits; if a
// second result is ready while the first is still stalled, the core holds until
// it leaves. reset clears the accumulators and control; palette contents stay
// undefined until written, and no clearing pass is run.
module linear_blend_skinning_core #(
    parameter int BONE_COUNT    = lbs_pkg::DEF_BONE_COUNT,
    parameter int FRACTION_BITS = lbs_pkg::DEF_FRACTION_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lbs_pkg::lbs_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output lbs_pkg::lbs_out_t result
);

    import lbs_pkg::*;

    localparam int PAL_DEPTH = BONE_COUNT * SLOT_SPAN;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int FULL_AW   = BONE_W + 2 + SLOT_W;

    lbs_ctrl_t                ctrl;
    lbs_in_t                  item_reg;
    lbs_out_t                 result_reg;
    logic                     result_valid_reg, result_valid_next;
    logic                     busy;
    logic                     item_xfer;
    logic                     bone_ok;
    logic                     slot_ok;
    logic                     ram_we;
    logic                     out_free;
    logic [FULL_AW-1:0]       waddr_full;
    logic [FULL_AW-1:0]       raddr_full;
    logic [WORD_W-1:0]        rdata;
    logic signed [ACC_W-1:0]  acc_x;
    logic signed [ACC_W-1:0]  acc_y;
    logic signed [ACC_W-1:0]  acc_z;
    logic [WORD_W:0]          sat_x;
    logic [WORD_W:0]          sat_y;
    logic [WORD_W:0]          sat_z;

    assign item_stall = busy;
    assign item_xfer  = item_valid && !item_stall;
    assign bone_ok    = 32'(item.bone_index) < 32'(BONE_COUNT);
    assign slot_ok    = 32'(item.matrix_slot) < 32'(SLOTS_PER_BONE);
    assign ram_we     = item_xfer && (item.action == ACTION_WRITE) && bone_ok && slot_ok;
    assign out_free   = !result_valid_reg || !result_stall;

    assign waddr_full = {2'b00, item.bone_index, item.matrix_slot};
    assign raddr_full = {2'b00, item_reg.bone_index, ctrl.row, ctrl.rd_col};

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            item_reg <= item;
        end
    end

    lbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PAL_DEPTH),
        .AW    (PAL_AW)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_full[PAL_AW-1:0]),
        .wdata (item.matrix_value),
        .re    (ctrl.rd_en),
        .raddr (raddr_full[PAL_AW-1:0]),
        .rdata (rdata)
    );

    lbs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (item_xfer && (item.action == ACTION_INFLUENCE)),
        .bone_ok  (bone_ok),
        .last_in  (item.last_influence),
        .out_free (out_free),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    lbs_math #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_math (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .rdata  (rdata),
        .pos_x  (item_reg.pos_x),
        .pos_y  (item_reg.pos_y),
        .pos_z  (item_reg.pos_z),
        .weight (item_reg.weight),
        .acc_x  (acc_x),
        .acc_y  (acc_y),
        .acc_z  (acc_z)
    );

    assign sat_x = sat_word(acc_x);
    assign sat_y = sat_word(acc_y);
    assign sat_z = sat_word(acc_z);

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (ctrl.emit)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            result_reg.out_x   <= sat_x[WORD_W-1:0];
            result_reg.out_y   <= sat_y[WORD_W-1:0];
            result_reg.out_z   <= sat_z[WORD_W-1:0];
            result_reg.clipped <= sat_x[WORD_W] | sat_y[WORD_W] | sat_z[WORD_W];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a result is only loaded into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> out_free)
        else $error("result loaded over a stalled result");

    // palette reads never collide with a palette write
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ctrl.rd_en))
        else $error("palette read and write in the same cycle");

    // accumulators start from zero after each vertex
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |=> (acc_x == '0) && (acc_y == '0) && (acc_z == '0))
        else $error("accumulators not cleared after a result");

endmodule

// ----- rtl/lbs_ram.sv -----
// lbs_ram: generic single-clock ram, one write port, one registered read port
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lbs_seq.sv -----
// lbs_seq: step sequencer for one influence, three matrix rows of nine steps
module lbs_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              bone_ok,
    input  logic              last_in,
    input  logic              out_free,
    output logic              busy,
    output lbs_pkg::lbs_ctrl_t ctrl
);

    import lbs_pkg::*;

    seq_state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] row_reg, row_next;
    logic       last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            step_reg  <= STEP_RD0;
            row_reg   <= 2'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        last_next  = last_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    last_next = last_in;
                    step_next = STEP_RD0;
                    row_next  = 2'd0;
                    if (bone_ok)
                    begin
                        state_next = SEQ_RUN;
                    end
                    else if (last_in)
                    begin
                        state_next = SEQ_EMIT;
                    end
                end
            end
            SEQ_RUN:
            begin
                if (step_reg == STEP_ACC)
                begin
                    step_next = STEP_RD0;
                    if (row_reg == ROW_LAST)
                    begin
                        row_next   = 2'd0;
                        state_next = last_reg ? SEQ_EMIT : SEQ_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 2'd1;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            SEQ_EMIT:
            begin
                if (out_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        ctrl.row = row_reg;
        busy     = (state_reg != SEQ_IDLE);
        case (state_reg)
            SEQ_RUN:
            begin
                case (step_reg)
                    STEP_RD0:
                    begin
                        ctrl.rd_en  = 1'b1;
                        ctrl.rd_col = step_reg[1:0];
                        ctrl.t_clr  = 1'b1;
                    end
                    STEP_RD1:
                    begin
                        ctrl.rd_en   = 1'b1;
                        ctrl.rd_col  = step_reg[1:0];
                        ctrl.mul_mat = 1'b1;
                        ctrl.p_col   = COL_X;
                    end
                    STEP_RD2:
                    begin
                        ctrl.rd_en   = 1'b1;
                        ctrl.rd_col  = step_reg[1:0];
                        ctrl.mul_mat = 1'b1;
                        ctrl.p_col   = COL_Y;
                        ctrl.t_add   = 1'b1;
                    end
                    STEP_RD3:
                    begin
                        ctrl.rd_en   = 1'b1;
                        ctrl.rd_col  = step_reg[1:0];
                        ctrl.mul_mat = 1'b1;
                        ctrl.p_col   = COL_Z;
                        ctrl.t_add   = 1'b1;
                    end
                    STEP_M3:
                    begin
                        ctrl.t_last = 1'b1;
                    end
                    STEP_LO:
                    begin
                        ctrl.mul_lo = 1'b1;
                    end
                    STEP_HI:
                    begin
                        ctrl.mul_hi = 1'b1;
                        ctrl.lo_cap = 1'b1;
                    end
                    STEP_WT:
                    begin
                        ctrl.wt_cap = 1'b1;
                    end
                    STEP_ACC:
                    begin
                        ctrl.acc_upd = 1'b1;
                    end
                    default:
                    begin
                        ctrl.rd_en = 1'b0;
                    end
                endcase
            end
            SEQ_EMIT:
            begin
                ctrl.emit = out_free;
            end
            default:
            begin
                ctrl.emit = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/lbs_math.sv -----
// lbs_math: shared multiplier, row sum, weight scaling and the three accumulators
module lbs_math #(
    parameter int FRACTION_BITS = lbs_pkg::DEF_FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lbs_pkg::lbs_ctrl_t                  ctrl,
    input  logic [lbs_pkg::WORD_W-1:0]          rdata,
    input  logic signed [lbs_pkg::WORD_W-1:0]   pos_x,
    input  logic signed [lbs_pkg::WORD_W-1:0]   pos_y,
    input  logic signed [lbs_pkg::WORD_W-1:0]   pos_z,
    input  logic [lbs_pkg::WEIGHT_W-1:0]        weight,
    output logic signed [lbs_pkg::ACC_W-1:0]    acc_x,
    output logic signed [lbs_pkg::ACC_W-1:0]    acc_y,
    output logic signed [lbs_pkg::ACC_W-1:0]    acc_z
);

    import lbs_pkg::*;

    localparam int OP_W   = WORD_W + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int LO_W   = WORD_W + WEIGHT_W;
    localparam int WSUM_W = PROD_W + WEIGHT_W - 2;

    logic signed [OP_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    logic signed [WORD_W-1:0] p_sel;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [ACC_W-1:0]  m3_ext;
    logic signed [ACC_W-1:0]  t_reg, t_next;
    logic [LO_W-1:0]          lo_reg;
    logic signed [WSUM_W-1:0] hi_ext;
    logic signed [WSUM_W-1:0] wsum;
    logic signed [WSUM_W-1:0] wsh;
    logic signed [ACC_W-1:0]  wt_reg;
    logic signed [ACC_W-1:0]  acc_reg [3];
    logic signed [ACC_W-1:0]  acc_sum;

    always_comb
    begin
        case (ctrl.p_col)
            COL_X:   p_sel = pos_x;
            COL_Y:   p_sel = pos_y;
            default: p_sel = pos_z;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (ctrl.mul_mat)
        begin
            mul_a = {rdata[WORD_W-1], rdata};
            mul_b = {p_sel[WORD_W-1], p_sel};
        end
        else if (ctrl.mul_lo)
        begin
            mul_a = {1'b0, t_reg[WORD_W-1:0]};
            mul_b = {{(OP_W-WEIGHT_W){1'b0}}, weight};
        end
        else if (ctrl.mul_hi)
        begin
            mul_a = {t_reg[ACC_W-1], t_reg[ACC_W-1:WORD_W]};
            mul_b = {{(OP_W-WEIGHT_W){1'b0}}, weight};
        end
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign prod_sh = prod_reg >>> FRACTION_BITS;
    assign m3_ext  = {{(ACC_W-WORD_W){rdata[WORD_W-1]}}, rdata};

    always_comb
    begin
        t_next = t_reg;
        if (ctrl.t_clr)
        begin
            t_next = '0;
        end
        else if (ctrl.t_add)
        begin
            t_next = t_reg + $signed(prod_sh[ACC_W-1:0]);
        end
        else if (ctrl.t_last)
        begin
            t_next = t_reg + $signed(prod_sh[ACC_W-1:0]) + m3_ext;
        end
    end

    // exact floor of t times weight over 2^15, from the two partial products
    assign hi_ext = {{(WSUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign wsum   = (hi_ext <<< WORD_W) + $signed({{(WSUM_W-LO_W){1'b0}}, lo_reg});
    assign wsh    = wsum >>> WEIGHT_SHIFT;

    assign acc_sum = sat_add64(acc_reg[ctrl.row], wt_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_mat || ctrl.mul_lo || ctrl.mul_hi)
        begin
            prod_reg <= prod_next;
        end
        t_reg <= t_next;
        if (ctrl.lo_cap)
        begin
            lo_reg <= prod_reg[LO_W-1:0];
        end
        if (ctrl.wt_cap)
        begin
            wt_reg <= wsh[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end
        else if (ctrl.emit)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end
        else if (ctrl.acc_upd)
        begin
            acc_reg[ctrl.row] <= acc_sum;
        end
    end

    assign acc_x = acc_reg[0];
    assign acc_y = acc_reg[1];
    assign acc_z = acc_reg[2];

endmodule

// ----- tb/tb_linear_blend_skinning_core.sv -----
// testbench of the skinning core: palette loads, weighted vertex blends and checked skinned positions
`timescale 1ns / 1ps

module tb_linear_blend_skinning_core;
    import lbs_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_GAP      = 6;
    localparam logic signed [ACC_W-1:0] WORD_TOP    = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] WORD_BOTTOM = -64'sd2147483648;
    localparam logic signed [ACC_W:0]   ACC_TOP     = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W:0]   ACC_BOTTOM  = -65'sh0_8000_0000_0000_0000;
    localparam logic [WEIGHT_W-1:0]     WEIGHT_ONE  = 16'd32768;
    localparam logic [WEIGHT_W-1:0]     WEIGHT_TOP  = 16'hFFFF;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_stall;
    lbs_in_t  item         = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    lbs_out_t result;

    logic signed [WORD_W-1:0] palette [DEF_BONE_COUNT][SLOTS_PER_BONE];
    logic signed [ACC_W-1:0]  blend_x = '0;
    logic signed [ACC_W-1:0]  blend_y = '0;
    logic signed [ACC_W-1:0]  blend_z = '0;
    lbs_out_t skinned_q [$];
    bit       bone_ready [DEF_BONE_COUNT];
    int       ready_count  = 0;
    int       items_sent   = 0;
    int       mismatches   = 0;
    int       quiet_cycles = 0;
    int       stall_left   = 0;
    bit       redraw_stall = 1'b1;
    bit       idle_on      = 1'b1;

    linear_blend_skinning_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one matrix row applied to the rest position with w = 1
    function automatic logic signed [ACC_W-1:0] bone_row(input int bone, input int row,
                                                         input lbs_in_t it);
        logic signed [ACC_W-1:0] coord [3];
        logic signed [ACC_W-1:0] m;
        logic signed [ACC_W-1:0] t;
        coord[0] = ACC_W'($signed(it.pos_x));
        coord[1] = ACC_W'($signed(it.pos_y));
        coord[2] = ACC_W'($signed(it.pos_z));
        t = ACC_W'($signed(palette[bone][row * 4 + 3]));
        for (int c = 0; c < 3; c++)
        begin
            m = ACC_W'($signed(palette[bone][row * 4 + c]));
            t = t + ((m * coord[c]) >>> DEF_FRACTION_BITS);
        end
        return t;
    endfunction

    function automatic logic signed [ACC_W-1:0] weighted(input logic signed [ACC_W-1:0] t,
                                                         input logic [WEIGHT_W-1:0] w);
        logic signed [95:0] wide;
        wide = 96'(t);
        wide = (wide * $signed({80'd0, w})) >>> WEIGHT_SHIFT;
        return wide[ACC_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a);
        s = s + (ACC_W+1)'(b);
        if (s > ACC_TOP)
            s = ACC_TOP;
        else if (s < ACC_BOTTOM)
            s = ACC_BOTTOM;
        return s[ACC_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] clamp_word(input logic signed [ACC_W-1:0] v,
                                                     inout logic clip);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > WORD_TOP)
        begin
            c = WORD_TOP;
            clip = 1'b1;
        end
        else if (v < WORD_BOTTOM)
        begin
            c = WORD_BOTTOM;
            clip = 1'b1;
        end
        return c[WORD_W-1:0];
    endfunction

    task automatic skin_item(input lbs_in_t it);
        lbs_out_t res;
        logic     clip;
        int       bone;
        bone = int'(it.bone_index);
        if (it.action == ACTION_WRITE)
        begin
            if (bone < DEF_BONE_COUNT && int'(it.matrix_slot) < SLOTS_PER_BONE)
                palette[it.bone_index][it.matrix_slot] = it.matrix_value;
        end
        else
        begin
            if (bone < DEF_BONE_COUNT)
            begin
                blend_x = sat_sum(blend_x, weighted(bone_row(bone, 0, it), it.weight));
                blend_y = sat_sum(blend_y, weighted(bone_row(bone, 1, it), it.weight));
                blend_z = sat_sum(blend_z, weighted(bone_row(bone, 2, it), it.weight));
            end
            if (it.last_influence)
            begin
                clip = 1'b0;
                res.out_x = clamp_word(blend_x, clip);
                res.out_y = clamp_word(blend_y, clip);
                res.out_z = clamp_word(blend_z, clip);
                res.clipped = clip;
                skinned_q.push_back(res);
                blend_x = '0;
                blend_y = '0;
                blend_z = '0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at %0t: got %h, want %h", what, $time, got, want);
        mismatches++;
    endtask

    // input transfers feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            skin_item(item);
    end

    always @(posedge clk)
    begin
        lbs_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            redraw_stall = 1'b1;
            if (skinned_q.size() == 0)
                report_mismatch("result with none pending", result.out_x, '0);
            else
            begin
                want = skinned_q.pop_front();
                if (result.out_x !== want.out_x)
                    report_mismatch("out_x", result.out_x, want.out_x);
                if (result.out_y !== want.out_y)
                    report_mismatch("out_y", result.out_y, want.out_y);
                if (result.out_z !== want.out_z)
                    report_mismatch("out_z", result.out_z, want.out_z);
                if (result.clipped !== want.clipped)
                    report_mismatch("clipped", 32'(result.clipped), 32'(want.clipped));
            end
        end
    end

    // receiver holds off each result for a drawn number of cycles
    always @(negedge clk)
    begin
        if (redraw_stall)
        begin
            stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            redraw_stall = 1'b0;
        end
        if (result_valid && stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (!result_valid)
            result_stall <= idle_on && ($urandom_range(0, 7) == 0);
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb_linear_blend_skinning_core: FAIL");
            $finish;
        end
    end

    task automatic send_item(input lbs_in_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
        items_sent++;
    endtask

    function automatic lbs_in_t palette_word(input int bone, input int slot,
                                             input logic [31:0] value, input logic last);
        lbs_in_t it;
        it.action = ACTION_WRITE;
        it.bone_index = BONE_W'(bone);
        it.matrix_slot = SLOT_W'(slot);
        it.matrix_value = value;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        it.weight = WEIGHT_W'($urandom);
        it.last_influence = last;
        return it;
    endfunction

    function automatic lbs_in_t influence(input int bone, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z,
                                          input logic [WEIGHT_W-1:0] w, input logic last);
        lbs_in_t it;
        it.action = ACTION_INFLUENCE;
        it.bone_index = BONE_W'(bone);
        it.matrix_slot = SLOT_W'($urandom);
        it.matrix_value = $urandom;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.weight = w;
        it.last_influence = last;
        return it;
    endfunction

    // matrix element within plus or minus four
    function automatic logic [31:0] small_q();
        return int'($urandom_range(0, 524287)) - 262144;
    endfunction

    // mostly within plus or minus 1024, sometimes anywhere
    function automatic logic [31:0] coord_q();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return int'($urandom_range(0, 32'h7FFFFFF)) - 32'h4000000;
    endfunction

    function automatic int pick_bone();
        int b;
        do
            b = $urandom_range(0, DEF_BONE_COUNT - 1);
        while (!bone_ready[b]);
        return b;
    endfunction

    task automatic load_bone(input int bone, input bit wide);
        int first;
        int slot;
        first = $urandom_range(0, SLOTS_PER_BONE - 1);
        for (int k = 0; k < SLOTS_PER_BONE; k++)
        begin
            slot = (first + k) % SLOTS_PER_BONE;
            send_item(palette_word(bone, slot, wide ? $urandom : small_q(),
                                   1'($urandom_range(0, 1))));
        end
        if (!bone_ready[bone])
            ready_count++;
        bone_ready[bone] = 1'b1;
    endtask

    // top bone with extreme elements, then writes that must be dropped
    task automatic test_palette_load();
        logic [31:0] rig [SLOTS_PER_BONE];
        rig = '{32'h7FFFFFFF, 32'h00000000, 32'h00000000, 32'h00010000,
                32'h00000000, 32'h00010000, 32'h80000000, 32'hFFFFFFFF,
                32'h00008000, 32'hFFFF0000, 32'h00010000, 32'h7FFFFFFF};
        for (int s = SLOTS_PER_BONE - 1; s >= 0; s--)
            send_item(palette_word(DEF_BONE_COUNT - 1, s, rig[s], s == 0));
        send_item(palette_word(DEF_BONE_COUNT - 1, 15, 32'hFFFFFFFF, 1'b1));
        send_item(palette_word(DEF_BONE_COUNT - 1, 12, 32'h80000000, 1'b0));
        bone_ready[DEF_BONE_COUNT - 1] = 1'b1;
        ready_count++;
    endtask

    task automatic test_weight_cases();
        int b;
        b = DEF_BONE_COUNT - 1;
        // vertex with a single zero-weight influence
        send_item(influence(b, $urandom, $urandom, $urandom, '0, 1'b1));
        send_item(influence(b, 32'h00010000, 32'h00020000, 32'hFFFD0000, WEIGHT_ONE, 1'b1));
        send_item(influence(b, 32'h00030000, 32'hFFFF8000, 32'h00001234, WEIGHT_TOP, 1'b1));
        send_item(influence(b, 32'h00100000, 32'h00000001, 32'hFFFFFFFF, 16'd10000, 1'b0));
        send_item(influence(b, 32'hFFF00000, 32'h00050000, 32'h00000000, 16'd12768, 1'b0));
        send_item(influence(b, 32'h00000000, 32'hFFFFFFFF, 32'h00070000, 16'd10000, 1'b1));
    endtask

    task automatic test_saturation();
        int b;
        b = DEF_BONE_COUNT - 1;
        send_item(influence(b, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, WEIGHT_ONE, 1'b1));
        send_item(influence(b, 32'h80000000, 32'h80000000, 32'h80000000, WEIGHT_TOP, 1'b1));
        send_item(influence(b, 32'h00000000, 32'h00000000, 32'h00000000, WEIGHT_ONE, 1'b1));
    endtask

    task automatic test_random_vertices();
        int next_switch;
        int pick;
        int n;
        int slot;
        logic [WEIGHT_W-1:0] w;
        next_switch = items_sent + 100;
        load_bone(0, 1'b0);
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_switch)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                next_switch += 100;
            end
            pick = $urandom_range(0, 99);
            if (pick < 6 || ready_count < 4)
                load_bone($urandom_range(0, DEF_BONE_COUNT - 1), $urandom_range(0, 3) == 0);
            else if (pick < 14)
            begin
                // lone word: live slots keep the bone loaded, slots past eleven are dropped
                slot = $urandom_range(0, 15);
                send_item(palette_word(pick_bone(), slot,
                                       ($urandom_range(0, 3) == 0) ? $urandom : small_q(),
                                       1'($urandom_range(0, 1))));
            end
            else if (pick < 20)
                send_item(influence(pick_bone(), coord_q(), coord_q(), coord_q(), '0, 1'b1));
            else
            begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(palette_word(pick_bone(), $urandom_range(0, 11), small_q(),
                                               1'($urandom_range(0, 1))));
                    case ($urandom_range(0, 7))
                        0: w = '0;
                        1: w = WEIGHT_ONE;
                        2: w = WEIGHT_TOP;
                        3: w = WEIGHT_W'($urandom_range(0, 65535));
                        default: w = WEIGHT_W'($urandom_range(0, 32768 / n));
                    endcase
                    send_item(influence(pick_bone(), coord_q(), coord_q(), coord_q(), w,
                                        k == n - 1));
                end
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_palette_load();
        test_weight_cases();
        test_saturation();
        test_random_vertices();
        item_valid <= 1'b0;
        while (skinned_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_linear_blend_skinning_core: PASS");
        else
            $display("tb_linear_blend_skinning_core: FAIL");
        $finish;
    end

endmodule
